// ===== hdl/ffla_pkg.sv =====
// ffla_pkg: shared types and constants of the frame free-list allocator
// no dependencies; imported by the channel interfaces and the core

package ffla_pkg;

  // fixed field widths of the request, result and configuration port
  localparam int ADDR_W     = 32;
  localparam int SHIFT_W    = 5;
  localparam int TOTAL_W    = 11;
  localparam int FREE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam int SHIFT_RESET = 12;
  localparam int TOTAL_RESET = 1024;

  typedef logic [ADDR_W-1:0] addr_t;

  // request kind
  typedef enum logic {
    REQ_RETAIN  = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_e;

  // result status
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_START  = 2'd0,
    CFG_FRAME_SHIFT = 2'd1,
    CFG_FRAME_TOTAL = 2'd2
  } cfg_reg_e;

endpackage

// ===== hdl/ffla_req_if.sv =====
// ffla_req_if: request channel of the frame allocator (valid/ready)
// depends on ffla_pkg for the field widths

interface ffla_req_if import ffla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [ADDR_W-1:0]   release_address;

  modport source (output valid, req_type, release_address, input ready);
  modport sink   (input valid, req_type, release_address, output ready);
endinterface

// ===== hdl/ffla_rsp_if.sv =====
// ffla_rsp_if: result channel of the frame allocator (valid/ready)
// depends on ffla_pkg for the field widths

interface ffla_rsp_if import ffla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   frame_address;
  logic [1:0]          status;
  logic [FREE_W-1:0]   free_count;

  modport source (output valid, frame_address, status, free_count, input ready);
  modport sink   (input valid, frame_address, status, free_count, output ready);
endinterface

// ===== hdl/frame_free_list_allocator_core.sv =====
// Frame allocator handing out fixed-size frames from one contiguous area.
// Free frame indices sit in a first-in first-out list held in a single-port
// style synchronous memory of MAX_FRAMES entries. For each request the
// accept cycle reads the list head from the memory, and the next cycle
// forms the result and writes a released index at the tail. A finished
// result waits in an output register, and the next request is taken in the
// same cycle that result is taken. No clearing pass is needed after reset or
// a configuration write: a count of pushes since the last refill tells which
// slots of the initial ascending run are still untouched, and those read as
// their own slot number. Any configuration write refills the list to all
// frames free; the user must write configuration only while no request is
// in flight; the block does not enforce it. frame_total above MAX_FRAMES is
// saturated to MAX_FRAMES. Depends on ffla_pkg, ffla_req_if and ffla_rsp_if

module frame_free_list_allocator_core import ffla_pkg::*; #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ffla_req_if.sink              req_i,
  ffla_rsp_if.source            rsp_o
);

  localparam int IW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int PW      = CNT_W + 1;
  localparam int N_RESET = (MAX_FRAMES < TOTAL_RESET) ? MAX_FRAMES : TOTAL_RESET;
  localparam int T_RESET = (N_RESET == MAX_FRAMES) ? 0 : N_RESET;

  // free list storage
  logic [IW-1:0] mem [MAX_FRAMES];
  logic [IW-1:0] rdata_q;
  logic          mem_we;

  // configuration
  addr_t              area_start_q, area_start_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]   n_cfg;
  logic               refill;

  // list state
  logic [IW-1:0]    head_q, head_d;
  logic [IW-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] wr_cnt_q, wr_cnt_d;

  // request in flight
  logic       busy_q, busy_d;
  logic       init_hit_q, init_hit_d;
  req_type_e  req_type_q;
  addr_t      release_address_q;
  logic       accept;

  // result register
  logic       out_valid_q, out_valid_d;
  addr_t      out_addr_q, out_addr_d;
  status_e    out_status_q, out_status_d;
  logic [CNT_W-1:0] out_free_q, out_free_d;

  // execute-cycle datapath
  addr_t         offset;
  addr_t         rel_idx;
  logic          rel_outside;
  logic          rel_full;
  logic [IW-1:0] pop_idx;
  addr_t         pop_addr;
  logic          head_in_run;
  logic          head_written;

  // handshake
  assign req_i.ready = !busy_q && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.frame_address = out_addr_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.free_count    = FREE_W'(out_free_q);

  // saturated frame count from a configuration write
  always_comb begin
    if (32'(cfg_wdata_i[TOTAL_W-1:0]) > 32'(MAX_FRAMES)) begin
      n_cfg = CNT_W'(MAX_FRAMES);
    end else begin
      n_cfg = CNT_W'(cfg_wdata_i[TOTAL_W-1:0]);
    end
  end

  // head slot still holds its initial index when pushes have not reached it
  assign head_in_run  = CNT_W'(head_q) < n_q;
  assign head_written = (PW'(wr_cnt_q) + PW'(n_q)) > (PW'(MAX_FRAMES) + PW'(head_q));
  assign init_hit_d   = head_in_run && !head_written;

  // release: frame index and range checks
  assign offset      = release_address_q - area_start_q;
  assign rel_idx     = offset >> shift_q;
  assign rel_outside = rel_idx >= 32'(n_q);
  assign rel_full    = free_q >= n_q;

  // retain: frame index and byte address
  assign pop_idx  = init_hit_q ? head_q : rdata_q;
  assign pop_addr = area_start_q + (32'(pop_idx) << shift_q);

  // next state
  always_comb begin
    area_start_d = area_start_q;
    shift_d      = shift_q;
    n_d          = n_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_d       = free_q;
    wr_cnt_d     = wr_cnt_q;
    busy_d       = busy_q;
    out_valid_d  = out_valid_q;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    out_free_d   = out_free_q;
    mem_we       = 1'b0;
    refill       = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      busy_d = 1'b1;
    end

    // execute the request in flight
    if (busy_q) begin
      busy_d       = 1'b0;
      out_valid_d  = 1'b1;
      out_addr_d   = '0;
      out_status_d = ST_OK;
      if (req_type_q == REQ_RETAIN) begin
        if (free_q == '0) begin
          out_status_d = ST_EMPTY;
        end else begin
          out_addr_d = pop_addr;
          head_d     = (head_q == IW'(MAX_FRAMES - 1)) ? '0 : head_q + 1'b1;
          free_d     = free_q - 1'b1;
        end
      end else begin
        if (rel_outside) begin
          out_status_d = ST_OUTSIDE;
        end else if (rel_full) begin
          out_status_d = ST_FULL;
        end else begin
          mem_we = 1'b1;
          tail_d = (tail_q == IW'(MAX_FRAMES - 1)) ? '0 : tail_q + 1'b1;
          free_d = free_q + 1'b1;
          if (wr_cnt_q != CNT_W'(MAX_FRAMES)) begin
            wr_cnt_d = wr_cnt_q + 1'b1;
          end
        end
      end
      out_free_d = free_d;
    end

    // configuration write refills the list
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_AREA_START: begin
          area_start_d = cfg_wdata_i;
          refill       = 1'b1;
        end
        CFG_FRAME_SHIFT: begin
          shift_d = cfg_wdata_i[SHIFT_W-1:0];
          refill  = 1'b1;
        end
        CFG_FRAME_TOTAL: begin
          n_d    = n_cfg;
          refill = 1'b1;
        end
        default: begin
        end
      endcase
      if (refill) begin
        head_d   = '0;
        tail_d   = (n_d == CNT_W'(MAX_FRAMES)) ? '0 : IW'(n_d);
        free_d   = n_d;
        wr_cnt_d = '0;
      end
    end
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_start_q <= '0;
      shift_q      <= SHIFT_W'(SHIFT_RESET);
      n_q          <= CNT_W'(N_RESET);
      head_q       <= '0;
      tail_q       <= IW'(T_RESET);
      free_q       <= CNT_W'(N_RESET);
      wr_cnt_q     <= '0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      area_start_q <= area_start_d;
      shift_q      <= shift_d;
      n_q          <= n_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      free_q       <= free_d;
      wr_cnt_q     <= wr_cnt_d;
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q        <= req_type_e'(req_i.req_type);
      release_address_q <= req_i.release_address;
      init_hit_q        <= init_hit_d;
    end
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
    out_free_q   <= out_free_d;
  end

  // free list memory: read head on accept, push released index at tail
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= rel_idx[IW-1:0];
    end
    if (accept) begin
      rdata_q <= mem[head_q];
    end
  end

endmodule

// ===== test/frame_free_list_allocator_core_tb.sv =====
// frame_free_list_allocator_core_tb: self-checking bench for the frame allocator core
// directed corner cases, then random retain/release traffic over many area settings
// depends on ffla_pkg, ffla_req_if, ffla_rsp_if and frame_free_list_allocator_core

module frame_free_list_allocator_core_tb;
  import ffla_pkg::*;

  localparam int LIST_DEPTH = 1024;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int RANDOM_REQUESTS = 1600;

  // one result as the core reports it
  typedef struct packed {
    addr_t             frame_address;
    status_e           status;
    logic [FREE_W-1:0] free_count;
  } alloc_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ffla_req_if req_ch ();
  ffla_rsp_if rsp_ch ();

  frame_free_list_allocator_core #(
    .MAX_FRAMES (LIST_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the allocator: configuration and free list
  addr_t              area_base;
  logic [SHIFT_W-1:0] shift_amt;
  logic [TOTAL_W-1:0] frame_count_cfg;
  logic [IDX_W-1:0]   free_ring [LIST_DEPTH];
  logic [IDX_W-1:0]   ring_head;
  logic [IDX_W-1:0]   ring_tail;
  logic [FREE_W-1:0]  free_frames_left;

  alloc_result_t expected_results [$];
  int            mismatch_count = 0;
  int            burst_left = 0;

  // frame count after saturation to the list depth
  function automatic logic [TOTAL_W-1:0] frames_in_area();
    return (frame_count_cfg > LIST_DEPTH) ? TOTAL_W'(LIST_DEPTH) : frame_count_cfg;
  endfunction

  // all frames free again, in ascending order
  function automatic void refill_free_ring();
    logic [TOTAL_W-1:0] n;
    int i;
    n = frames_in_area();
    for (i = 0; i < LIST_DEPTH; i++) begin
      free_ring[i] = (i < n) ? IDX_W'(i) : '0;
    end
    ring_head = '0;
    ring_tail = IDX_W'(n % LIST_DEPTH);
    free_frames_left = FREE_W'(n);
  endfunction

  // expected result of one request, advancing the shadow state
  function automatic alloc_result_t predict_allocation(input req_type_e kind,
                                                       input addr_t addr);
    alloc_result_t r;
    logic [TOTAL_W-1:0] n;
    logic [31:0] offset;
    logic [31:0] frame_idx;
    n = frames_in_area();
    r.frame_address = '0;
    r.status = ST_OK;
    if (kind == REQ_RETAIN) begin
      if (free_frames_left == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.frame_address = area_base + (32'(free_ring[ring_head]) << shift_amt);
        ring_head = ring_head + 1'b1;
        free_frames_left = free_frames_left - 1'b1;
      end
    end else begin
      offset = addr - area_base;
      frame_idx = offset >> shift_amt;
      if (frame_idx >= 32'(n)) begin
        r.status = ST_OUTSIDE;
      end else if (free_frames_left >= n) begin
        r.status = ST_FULL;
      end else begin
        free_ring[ring_tail] = frame_idx[IDX_W-1:0];
        ring_tail = ring_tail + 1'b1;
        free_frames_left = free_frames_left + 1'b1;
      end
    end
    r.free_count = free_frames_left;
    return r;
  endfunction

  task automatic note_failure(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch in %0s: expected %h, got %h at %0t", what, want, got, $time);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    alloc_result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        note_failure("unexpected result address", '0, rsp_ch.frame_address);
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.frame_address !== want.frame_address) begin
          note_failure("frame_address", want.frame_address, rsp_ch.frame_address);
        end
        if (rsp_ch.status !== want.status) begin
          note_failure("status", 32'(want.status), 32'(rsp_ch.status));
        end
        if (rsp_ch.free_count !== want.free_count) begin
          note_failure("free_count", 32'(want.free_count), 32'(rsp_ch.free_count));
        end
      end
    end
  end

  // result side back-pressure, switching between stall patterns
  initial begin : result_stall
    stall_mode_e mode;
    int left;
    int tick;
    rsp_ch.ready = 1'b0;
    mode = STALL_NONE;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
      end
      left--;
      tick++;
      case (mode)
        STALL_NONE:     rsp_ch.ready <= 1'b1;
        STALL_RANDOM:   rsp_ch.ready <= 1'($urandom_range(0, 1));
        STALL_HEAVY:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default:        rsp_ch.ready <= ((tick % 5) < 3);
      endcase
    end
  end

  // send one request in bursts with random gaps, predict on accept
  task automatic send_request(input req_type_e kind, input addr_t addr,
                              output alloc_result_t predicted);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.release_address <= addr;
    do @(posedge clk_i); while (!req_ch.ready);
    predicted = predict_allocation(kind, addr);
    expected_results.push_back(predicted);
  endtask

  // stop sending and let every pending result drain
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e index, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      CFG_AREA_START:  area_base = data;
      CFG_FRAME_SHIFT: shift_amt = data[SHIFT_W-1:0];
      CFG_FRAME_TOTAL: frame_count_cfg = data[TOTAL_W-1:0];
      default: ;
    endcase
    refill_free_ring();
    @(posedge clk_i);
  endtask

  task automatic configure_area(input addr_t start, input logic [SHIFT_W-1:0] shift,
                                input logic [TOTAL_W-1:0] total);
    wait_idle();
    write_register(CFG_AREA_START, start);
    write_register(CFG_FRAME_SHIFT, 32'(shift));
    write_register(CFG_FRAME_TOTAL, 32'(total));
  endtask

  // reset settings: 1024 frames of 4 KiB at address 0
  task automatic test_reset_state();
    alloc_result_t r;
    send_request(REQ_RETAIN, 32'hFFFF_FFFF, r);
    send_request(REQ_RETAIN, 32'h0000_0000, r);
    send_request(REQ_RELEASE, 32'h0000_1FFF, r);   // misaligned, rounds down
    send_request(REQ_RELEASE, 32'h0040_0000, r);   // first frame past the end
    send_request(REQ_RELEASE, 32'hFFFF_FFFF, r);
    send_request(REQ_RELEASE, 32'h0000_0000, r);   // list full again after this
    send_request(REQ_RELEASE, 32'h0000_2000, r);
    wait_idle();
  endtask

  // three frames whose addresses wrap past 2^32
  task automatic test_wrapping_area();
    alloc_result_t r;
    configure_area(32'hFFFF_E000, 5'd12, 11'd3);
    repeat (4) send_request(REQ_RETAIN, $urandom, r);  // last one finds the list empty
    send_request(REQ_RELEASE, 32'h0000_0ABC, r);
    send_request(REQ_RELEASE, 32'hFFFF_DFFF, r);   // just below the area
    send_request(REQ_RELEASE, 32'h0000_1000, r);   // just above the area
    send_request(REQ_RELEASE, 32'hFFFF_E000, r);
    send_request(REQ_RELEASE, 32'hFFFF_F123, r);
    send_request(REQ_RELEASE, 32'hFFFF_E000, r);   // duplicate into a full list
    wait_idle();
  endtask

  // area with no frames at all
  task automatic test_empty_area();
    alloc_result_t r;
    configure_area(32'h0000_0000, 5'd12, 11'd0);
    send_request(REQ_RETAIN, 32'h0000_0000, r);
    send_request(REQ_RELEASE, 32'h0000_0000, r);
    wait_idle();
  endtask

  // largest and smallest frame sizes, saturated frame count
  task automatic test_extreme_shifts();
    alloc_result_t r;
    configure_area(32'h0000_0000, 5'd31, 11'd2047);
    send_request(REQ_RETAIN, 32'h0000_0000, r);
    send_request(REQ_RETAIN, 32'h0000_0000, r);
    send_request(REQ_RELEASE, 32'hFFFF_FFFF, r);
    configure_area(32'h8000_0001, 5'd0, 11'd1);
    send_request(REQ_RETAIN, 32'h0000_0000, r);
    send_request(REQ_RETAIN, 32'h0000_0000, r);
    send_request(REQ_RELEASE, 32'h8000_0001, r);
    send_request(REQ_RELEASE, 32'h8000_0002, r);
    send_request(REQ_RELEASE, 32'h8000_0001, r);
    wait_idle();
  endtask

  // random area settings, mostly releases of frames actually held
  task automatic test_random_traffic();
    alloc_result_t r;
    addr_t held [$];
    addr_t start;
    addr_t addr;
    logic [31:0] frame_mask;
    logic [SHIFT_W-1:0] shift;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] n;
    req_type_e kind;
    int sent;
    int phase_len;
    int retain_bias;
    int pick;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      // pick the next area setting
      shift = 5'($urandom_range(0, 20));
      total = 11'($urandom_range(1, 64));
      case ($urandom_range(0, 9))
        0: begin
          shift = 5'd12;
          total = 11'd1024;
        end
        1: total = 11'd0;
        2: total = 11'd2047;
        3: shift = 5'd0;
        4: begin
          shift = 5'd31;
          total = 11'($urandom_range(1, 4));
        end
        5: total = 11'($urandom_range(1, 2047));
        default: ;
      endcase
      frame_mask = (32'd1 << shift) - 1;
      start = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & ~frame_mask);
      configure_area(start, shift, total);
      n = frames_in_area();
      held.delete();
      phase_len = $urandom_range(60, 180);
      retain_bias = $urandom_range(10, 90);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          // stray or duplicate requests
          kind = ($urandom_range(0, 4) == 0) ? REQ_RETAIN : REQ_RELEASE;
          case ($urandom_range(0, 3))
            0: addr = $urandom;
            1: addr = area_base + (32'(n) << shift_amt) + ($urandom & frame_mask);
            2: addr = area_base - 32'($urandom_range(1, 16));
            default: begin
              addr = (n == 0) ? $urandom
                   : area_base + (32'($urandom_range(0, n - 1)) << shift_amt);
            end
          endcase
        end else if (held.size() == 0 || $urandom_range(0, 99) < retain_bias) begin
          kind = REQ_RETAIN;
          addr = $urandom;
        end else begin
          // give back a held frame, anywhere inside it
          kind = REQ_RELEASE;
          pick = $urandom_range(0, held.size() - 1);
          addr = held[pick] + ($urandom & frame_mask);
          held.delete(pick);
        end
        send_request(kind, addr, r);
        sent++;
        if (kind == REQ_RETAIN && r.status == ST_OK) begin
          held.push_back(r.frame_address);
        end
      end
    end
    wait_idle();
  endtask

  // run limit
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_RETAIN;
    req_ch.release_address = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_AREA_START;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    area_base = '0;
    shift_amt = SHIFT_W'(SHIFT_RESET);
    frame_count_cfg = TOTAL_W'(TOTAL_RESET);
    refill_free_ring();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_wrapping_area();
    test_empty_area();
    test_extreme_shifts();
    test_random_traffic();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      mismatch_count += expected_results.size();
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== frame_free_list_allocator_core.f =====
hdl/ffla_pkg.sv
hdl/ffla_req_if.sv
hdl/ffla_rsp_if.sv
hdl/frame_free_list_allocator_core.sv
test/frame_free_list_allocator_core_tb.sv
